FILE: design/s2lab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package s2lab_pkg;

  localparam int unsigned OUT_FRAC_BITS_DEF = 8;
  localparam int unsigned Q_BITS            = 20;
  localparam int unsigned CODE_W            = 8;
  localparam int unsigned LIN_W             = 21;   // Q20 values up to just over 1.0
  localparam int unsigned NUM_W             = 38;   // XYZ numerators
  localparam int unsigned L_W               = 15;
  localparam int unsigned AB_W              = 16;

  localparam int unsigned DIV_STAGES = 4;           // split multiply, sum, back-multiply, fix
  localparam int unsigned SEG_STAGES = LIN_W;       // one cube-root bit per stage
  // lut + matrix + dividers + segment + L/a/b products
  localparam int unsigned PIPE_DEPTH = 2 + DIV_STAGES + SEG_STAGES + 1;

  // White point normalization
  localparam longint unsigned X_DIV  = 95047;
  localparam longint unsigned Y_DIV  = 10000;
  localparam longint unsigned Z_DIV  = 108883;
  localparam longint unsigned X_BIAS = 47523;
  localparam longint unsigned Y_BIAS = 5000;
  localparam longint unsigned Z_BIAS = 54441;

  // Linear segment: f = (7787 v + 500) / 1000 + 16/116
  localparam int unsigned SEG_KNEE    = 9286;       // v > knee takes the cube root
  localparam int unsigned LIN_V_W     = 14;
  localparam int unsigned LIN_N_W     = 27;
  localparam int unsigned LIN_P_W     = 55;
  localparam int unsigned LIN_MUL     = 7787;
  localparam int unsigned LIN_RND     = 500;
  localparam longint unsigned RECIP_1000 = 137438954;  // ceil(2^37 / 1000)
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned SEG_OFFSET  = 144631;     // 16/116 in Q20

  typedef logic [LIN_W-1:0] lin_lut_t [256];

  function automatic longint unsigned pow5_q(input longint unsigned r);
    longint unsigned q;
    q = (r * r) >> Q_BITS;
    q = (q * q) >> Q_BITS;
    return (q * r) >> Q_BITS;
  endfunction

  // sRGB decode of one code to linear Q20
  function automatic logic [LIN_W-1:0] lin_entry(input longint unsigned c);
    longint unsigned t;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned res;
    if (c * 100000 > 4045 * 255) begin
      t  = ((1000 * c + 14025) << Q_BITS) / 269025;
      lo = 0;
      hi = 64'd1 << Q_BITS;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (pow5_q(mid) <= t) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      res = (((t * t) >> Q_BITS) * ((lo * lo) >> Q_BITS)) >> Q_BITS;
    end else begin
      res = (c * 100 * (64'd1 << Q_BITS) + 164730) / 329460;
    end
    return LIN_W'(res);
  endfunction

  function automatic lin_lut_t build_lut();
    lin_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = lin_entry(longint'(i));
    end
    return lut;
  endfunction

  localparam lin_lut_t LIN_LUT = build_lut();

endpackage

`default_nettype wire

FILE: design/s2lab_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface s2lab_pix_if;
  logic                          valid;
  logic                          ready;
  logic [s2lab_pkg::CODE_W-1:0]  red;
  logic [s2lab_pkg::CODE_W-1:0]  green;
  logic [s2lab_pkg::CODE_W-1:0]  blue;
  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

interface s2lab_lab_if;
  logic                              valid;
  logic                              ready;
  logic [s2lab_pkg::L_W-1:0]         lightness;
  logic signed [s2lab_pkg::AB_W-1:0] green_red_axis;
  logic signed [s2lab_pkg::AB_W-1:0] blue_yellow_axis;
  modport source(output valid, lightness, green_red_axis, blue_yellow_axis, input ready);
  modport sink(input valid, lightness, green_red_axis, blue_yellow_axis, output ready);
endinterface

`default_nettype wire

FILE: design/srgb_to_cielab_core.sv
`timescale 1ns / 1ps
`default_nettype none

// sRGB to CIELAB (D65, 2 degree observer) converter. Takes one 8-bit
// R/G/B transaction per cycle and returns L*, a* and b* with OUT_FRAC_BITS
// fraction bits; L* is clamped to 0..100, capped at code 32767, and a* and
// b* saturate to 16 bits. Throughput is one pixel per clock; the pipeline
// is 29 register stages deep (LUT, matrix, 4 divider stages, 21 cube-root
// stages, L/a/b products, output register). The cube-root pipeline, one
// bit per stage, sets that depth. The whole pipeline advances together: it
// moves whenever the output register is empty or being drained, so ready
// stays high unless a result is held by the sink.
module srgb_to_cielab_core #(
  parameter int unsigned OUT_FRAC_BITS = s2lab_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  s2lab_pix_if.sink     pix_i,
  s2lab_lab_if.source   lab_o
);

  localparam int unsigned LW       = s2lab_pkg::LIN_W;
  localparam int unsigned NW       = s2lab_pkg::NUM_W;
  localparam int unsigned Depth    = s2lab_pkg::PIPE_DEPTH;
  localparam int unsigned RawW     = 34;
  localparam int unsigned RndShift = s2lab_pkg::Q_BITS - OUT_FRAC_BITS;
  localparam int          LMaxFull = 100 << OUT_FRAC_BITS;
  localparam int          LMax     = (LMaxFull > 32767) ? 32767 : LMaxFull;
  localparam logic signed [RawW-1:0] HalfS  = RawW'(1) << (RndShift - 1);
  localparam logic signed [RawW-1:0] LMaxS  = RawW'(LMax);
  localparam logic signed [RawW-1:0] AbMaxS = RawW'(32767);
  localparam logic signed [RawW-1:0] AbMinS = -RawW'(32768);

  // Global advance: output register empty or being taken
  logic             adv;
  logic [Depth-1:0] vld_q;
  logic             out_v_q;

  assign adv         = !out_v_q || lab_o.ready;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      vld_q   <= {vld_q[Depth-2:0], pix_i.valid};
      out_v_q <= vld_q[Depth-1];
    end
  end

  // Stage 1: gamma decode through the ROM
  logic [LW-1:0] lin_r_q, lin_g_q, lin_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin_r_q <= s2lab_pkg::LIN_LUT[pix_i.red];
      lin_g_q <= s2lab_pkg::LIN_LUT[pix_i.green];
      lin_b_q <= s2lab_pkg::LIN_LUT[pix_i.blue];
    end
  end

  // Stage 2: RGB to XYZ (coefficients x 10000), white point numerators
  logic [NW-1:0] sx_d, sy_d, sz_d;
  logic [NW-1:0] nx_q, ny_q, nz_q;

  always_comb begin
    sx_d = NW'(lin_r_q) * NW'(4124) + NW'(lin_g_q) * NW'(3576) + NW'(lin_b_q) * NW'(1805);
    sy_d = NW'(lin_r_q) * NW'(2126) + NW'(lin_g_q) * NW'(7152) + NW'(lin_b_q) * NW'(722);
    sz_d = NW'(lin_r_q) * NW'(193)  + NW'(lin_g_q) * NW'(1192) + NW'(lin_b_q) * NW'(9505);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= sx_d * NW'(10) + NW'(s2lab_pkg::X_BIAS);
      ny_q <= sy_d + NW'(s2lab_pkg::Y_BIAS);
      nz_q <= sz_d * NW'(10) + NW'(s2lab_pkg::Z_BIAS);
    end
  end

  // Normalized X/Y/Z in Q20
  logic [LW-1:0] qx, qy, qz;

  s2lab_div #(.DIVISOR(s2lab_pkg::X_DIV), .NUM_W(NW), .QUO_W(LW))
    u_div_x (.clk_i(clk_i), .en_i(adv), .num_i(nx_q), .quo_o(qx));
  s2lab_div #(.DIVISOR(s2lab_pkg::Y_DIV), .NUM_W(NW), .QUO_W(LW))
    u_div_y (.clk_i(clk_i), .en_i(adv), .num_i(ny_q), .quo_o(qy));
  s2lab_div #(.DIVISOR(s2lab_pkg::Z_DIV), .NUM_W(NW), .QUO_W(LW))
    u_div_z (.clk_i(clk_i), .en_i(adv), .num_i(nz_q), .quo_o(qz));

  // f(x), f(y), f(z)
  logic [LW-1:0] fx, fy, fz;

  s2lab_seg u_seg_x (.clk_i(clk_i), .en_i(adv), .v_i(qx), .f_o(fx));
  s2lab_seg u_seg_y (.clk_i(clk_i), .en_i(adv), .v_i(qy), .f_o(fy));
  s2lab_seg u_seg_z (.clk_i(clk_i), .en_i(adv), .v_i(qz), .f_o(fz));

  // L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz), all Q20
  logic signed [RawW-1:0] l_raw_q, a_raw_q, b_raw_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_raw_q <= RawW'(116) * RawW'(fy) - (RawW'(16) << s2lab_pkg::Q_BITS);
      a_raw_q <= RawW'(500) * (RawW'(fx) - RawW'(fy));
      b_raw_q <= RawW'(200) * (RawW'(fy) - RawW'(fz));
    end
  end

  // Round half up, then clamp / saturate
  logic signed [RawW-1:0] l_rnd, a_rnd, b_rnd;
  logic [s2lab_pkg::L_W-1:0]         l_d;
  logic signed [s2lab_pkg::AB_W-1:0] a_d, b_d;

  always_comb begin
    l_rnd = (l_raw_q + HalfS) >>> RndShift;
    a_rnd = (a_raw_q + HalfS) >>> RndShift;
    b_rnd = (b_raw_q + HalfS) >>> RndShift;

    if (l_rnd < 0) begin
      l_d = '0;
    end else if (l_rnd > LMaxS) begin
      l_d = s2lab_pkg::L_W'(LMax);
    end else begin
      l_d = l_rnd[s2lab_pkg::L_W-1:0];
    end

    if (a_rnd > AbMaxS) begin
      a_d = 16'sh7fff;
    end else if (a_rnd < AbMinS) begin
      a_d = -16'sh8000;
    end else begin
      a_d = a_rnd[s2lab_pkg::AB_W-1:0];
    end

    if (b_rnd > AbMaxS) begin
      b_d = 16'sh7fff;
    end else if (b_rnd < AbMinS) begin
      b_d = -16'sh8000;
    end else begin
      b_d = b_rnd[s2lab_pkg::AB_W-1:0];
    end
  end

  logic [s2lab_pkg::L_W-1:0]         l_q;
  logic signed [s2lab_pkg::AB_W-1:0] a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q <= l_d;
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign lab_o.valid            = out_v_q;
  assign lab_o.lightness        = l_q;
  assign lab_o.green_red_axis   = a_q;
  assign lab_o.blue_yellow_axis = b_q;

endmodule

`default_nettype wire

FILE: design/s2lab_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Divider by a constant: reciprocal multiply (numerator split in halves),
// then one back-multiply and a single +1 fix. Four register stages.
module s2lab_div #(
  parameter longint unsigned DIVISOR = s2lab_pkg::Y_DIV,
  parameter int unsigned     NUM_W   = s2lab_pkg::NUM_W,
  parameter int unsigned     QUO_W   = s2lab_pkg::LIN_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [QUO_W-1:0] quo_o
);

  // floor(2^NUM_W / d): estimate is the true quotient or one below it
  localparam longint unsigned Recip = (64'd1 << NUM_W) / DIVISOR;
  localparam int unsigned     MW    = $clog2(Recip + 1);
  localparam int unsigned     LoW   = NUM_W / 2;
  localparam int unsigned     HiW   = NUM_W - LoW;
  localparam int unsigned     PW    = NUM_W + MW;

  logic [HiW+MW-1:0] p_hi_q;
  logic [LoW+MW-1:0] p_lo_q;
  logic [NUM_W-1:0]  n_a_q, n_b_q, n_c_q;
  logic [PW-1:0]     prod;
  logic [QUO_W-1:0]  q_est_q, q_est_c_q;
  logic [NUM_W-1:0]  qd_q;
  logic [NUM_W-1:0]  rem;
  logic [QUO_W-1:0]  quo_q;

  assign prod = (PW'(p_hi_q) << LoW) + PW'(p_lo_q);
  assign rem  = n_c_q - qd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // partial products
      p_hi_q    <= (HiW+MW)'(num_i[NUM_W-1:LoW]) * (HiW+MW)'(Recip);
      p_lo_q    <= (LoW+MW)'(num_i[LoW-1:0]) * (LoW+MW)'(Recip);
      n_a_q     <= num_i;
      // quotient estimate
      q_est_q   <= prod[NUM_W +: QUO_W];
      n_b_q     <= n_a_q;
      // back-multiply
      qd_q      <= NUM_W'(q_est_q) * NUM_W'(DIVISOR);
      q_est_c_q <= q_est_q;
      n_c_q     <= n_b_q;
      // remainder at or above d means the estimate was one short
      quo_q     <= q_est_c_q + QUO_W'(rem >= NUM_W'(DIVISOR));
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

FILE: design/s2lab_seg.sv
`timescale 1ns / 1ps
`default_nettype none

// Lab companding f(v): digit-serial cube root (3 bits of v*2^40 per stage)
// with the linear segment computed alongside and picked at the end.
module s2lab_seg (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [s2lab_pkg::LIN_W-1:0] v_i,
  output logic [s2lab_pkg::LIN_W-1:0] f_o
);

  localparam int unsigned VW    = s2lab_pkg::LIN_W;
  localparam int unsigned Steps = s2lab_pkg::SEG_STAGES;
  localparam int unsigned TW    = 3 * Steps;
  localparam int unsigned Y2W   = 2 * VW;
  localparam int unsigned RW    = 48;

  logic [VW-1:0]  v_q   [Steps];
  logic [VW-1:0]  y_q   [Steps];
  logic [Y2W-1:0] y2_q  [Steps];
  logic [RW-1:0]  r_q   [Steps];
  logic           sel_q [Steps];

  logic [s2lab_pkg::LIN_N_W-1:0] lin_n_q;
  logic [s2lab_pkg::LIN_P_W-1:0] lin_p_q;
  logic [VW-1:0]                 lin_f_q [Steps-2];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned Grp = Steps - 1 - k;
    logic [VW-1:0]  v_in;
    logic [VW-1:0]  y_in;
    logic [Y2W-1:0] y2_in;
    logic [RW-1:0]  r_in;
    logic           sel_in;
    logic [TW-1:0]  tgt;
    logic [RW-1:0]  r_sh;
    logic [RW-1:0]  trial;
    logic           take;

    if (k == 0) begin : g_first
      assign v_in   = v_i;
      assign y_in   = '0;
      assign y2_in  = '0;
      assign r_in   = '0;
      assign sel_in = (v_i > VW'(s2lab_pkg::SEG_KNEE));
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign y_in   = y_q[k-1];
      assign y2_in  = y2_q[k-1];
      assign r_in   = r_q[k-1];
      assign sel_in = sel_q[k-1];
    end

    assign tgt   = TW'(v_in) << (2 * s2lab_pkg::Q_BITS);
    assign r_sh  = (r_in << 3) | RW'(tgt[3*Grp+2 -: 3]);
    // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
    assign trial = RW'(y2_in) * RW'(12) + RW'(y_in) * RW'(6) + RW'(1);
    assign take  = (r_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k]   <= v_in;
        sel_q[k] <= sel_in;
        r_q[k]   <= take ? (r_sh - trial) : r_sh;
        y_q[k]   <= {y_in[VW-2:0], take};
        y2_q[k]  <= take ? ((y2_in << 2) + (Y2W'(y_in) << 2) + Y2W'(1)) : (y2_in << 2);
      end
    end
  end

  // Linear segment, divide by 1000 through an exact reciprocal
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_n_q <= s2lab_pkg::LIN_N_W'(v_i[s2lab_pkg::LIN_V_W-1:0])
                 * s2lab_pkg::LIN_N_W'(s2lab_pkg::LIN_MUL)
                 + s2lab_pkg::LIN_N_W'(s2lab_pkg::LIN_RND);
      lin_p_q <= s2lab_pkg::LIN_P_W'(lin_n_q) * s2lab_pkg::LIN_P_W'(s2lab_pkg::RECIP_1000);
      lin_f_q[0] <= VW'(lin_p_q[s2lab_pkg::LIN_P_W-1:s2lab_pkg::RECIP_SHIFT])
                    + VW'(s2lab_pkg::SEG_OFFSET);
      for (int i = 1; i < Steps - 2; i++) begin
        lin_f_q[i] <= lin_f_q[i-1];
      end
    end
  end

  assign f_o = sel_q[Steps-1] ? y_q[Steps-1] : lin_f_q[Steps-3];

endmodule

`default_nettype wire

FILE: design/s2lab_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module s2lab_checker #(
  parameter int unsigned OUT_FRAC_BITS = s2lab_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [s2lab_pkg::L_W-1:0]         lightness_i,
  input logic signed [s2lab_pkg::AB_W-1:0] green_red_axis_i,
  input logic signed [s2lab_pkg::AB_W-1:0] blue_yellow_axis_i
);

  localparam int LMaxFull = 100 << OUT_FRAC_BITS;
  localparam int LMax     = (LMaxFull > 32767) ? 32767 : LMaxFull;

  // Held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(lightness_i)
      && $stable(green_red_axis_i) && $stable(blue_yellow_axis_i))
    else $error("held result changed");

  // Input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Empty output never blocks input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while output empty");

  // Lightness stays within its clamp
  a_l_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(lightness_i) <= LMax))
    else $error("lightness above range");

endmodule

bind srgb_to_cielab_core s2lab_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_s2lab_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (pix_i.ready),
  .out_valid_i       (lab_o.valid),
  .out_ready_i       (lab_o.ready),
  .lightness_i       (lab_o.lightness),
  .green_red_axis_i  (lab_o.green_red_axis),
  .blue_yellow_axis_i(lab_o.blue_yellow_axis)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned OFB        = 8;
  localparam int unsigned NUM_RANDOM = 1700;
  localparam int unsigned HOLD_LEN   = 300;    // long sink stall, cycles
  localparam int unsigned DRAIN_WAIT = 80;     // extra wait after the scoreboard empties
  localparam int unsigned CYCLE_CAP  = 400000;

  typedef struct packed {
    logic [s2lab_pkg::L_W-1:0]         lightness;
    logic signed [s2lab_pkg::AB_W-1:0] green_red_axis;
    logic signed [s2lab_pkg::AB_W-1:0] blue_yellow_axis;
  } lab_t;

  typedef struct {
    logic [7:0] r, g, b;
    bit         typed;   // expected value given in the row
    lab_t       lab;
  } pix_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  s2lab_pix_if pix ();
  s2lab_lab_if lab ();

  srgb_to_cielab_core #(.OUT_FRAC_BITS(OFB)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix.sink),
    .lab_o (lab.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Color predictor: sRGB decode, XYZ, f(t) segment, L*/a*/b* in Q20
  // ---------------------------------------------------------------------------
  longint unsigned decode_tab [256];

  function automatic longint unsigned fifth_pow(input longint unsigned x);
    longint unsigned q;
    q = (x * x) >> 20;
    q = (q * q) >> 20;
    return (q * x) >> 20;
  endfunction

  function automatic longint unsigned srgb_decode(input longint unsigned code);
    longint unsigned t, lo, hi, mid;
    if (code * 100000 > 4045 * 255) begin
      t  = ((1000 * code + 14025) << 20) / 269025;
      lo = 0;
      hi = 64'd1 << 20;
      // root: largest R with R^5 <= t, so t^2.4 = t^2 * R^2
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (fifth_pow(mid) <= t) lo = mid;
        else hi = mid - 1;
      end
      return (((t * t) >> 20) * ((lo * lo) >> 20)) >> 20;
    end
    return (code * 100 * (64'd1 << 20) + 164730) / 329460;
  endfunction

  function automatic longint unsigned lab_curve(input longint unsigned v);
    longint unsigned goal, lo, hi, mid;
    if (v * 1000000 > 8856 * (64'd1 << 20)) begin
      goal = v << 40;
      lo   = 0;
      hi   = (64'd1 << 21) - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * mid <= goal) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    end
    return (7787 * v + 500) / 1000 + (16 * (64'd1 << 20) + 58) / 116;
  endfunction

  // Q20 to OFB fraction bits, half rounds toward +inf
  function automatic longint q20_round(input longint v);
    longint unsigned sh, half, m;
    sh   = 20 - OFB;
    half = 64'd1 << (sh - 1);
    if (v >= 0) return longint'((unsigned'(v) + half) >> sh);
    m = unsigned'(-v);
    if (m <= half) return 0;
    return -longint'((m - half + (64'd1 << sh) - 1) >> sh);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_t lab_of_pixel(input logic [7:0] r, g, b);
    longint unsigned lr, lg, lb, sx, sy, sz;
    longint fx, fy, fz, lmax;
    lab_t res;
    lr = decode_tab[r];
    lg = decode_tab[g];
    lb = decode_tab[b];
    sx = 4124 * lr + 3576 * lg + 1805 * lb;
    sy = 2126 * lr + 7152 * lg + 722 * lb;
    sz = 193 * lr + 1192 * lg + 9505 * lb;
    fx = longint'(lab_curve((sx * 10 + 47523) / 95047));
    fy = longint'(lab_curve((sy + 5000) / 10000));
    fz = longint'(lab_curve((sz * 10 + 54441) / 108883));
    lmax = 100 << OFB;
    if (lmax > 32767) lmax = 32767;
    res.lightness        = s2lab_pkg::L_W'(clip(q20_round(116 * fy - (64'sd16 << 20)),
                                                0, lmax));
    res.green_red_axis   = s2lab_pkg::AB_W'(clip(q20_round(500 * (fx - fy)), -32768, 32767));
    res.blue_yellow_axis = s2lab_pkg::AB_W'(clip(q20_round(200 * (fy - fz)), -32768, 32767));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: expectations pushed on input accept, popped on output accept
  // ---------------------------------------------------------------------------
  lab_t        pending_lab [$];
  int unsigned pix_taken = 0;
  int unsigned cycle_cnt = 0;
  bit          failed    = 1'b0;
  lab_t        row_lab;
  bit          row_typed;

  always @(posedge clk_i) begin
    lab_t want;
    lab_t got;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("tb_top: FAIL");
      $finish;
    end
    if (rst_ni && pix.valid && pix.ready) begin
      // typed rows carry their own value; the rest come from the predictor
      pending_lab.push_back(row_typed ? row_lab : lab_of_pixel(pix.red, pix.green, pix.blue));
      pix_taken = pix_taken + 1;
    end
    if (rst_ni && lab.valid && lab.ready) begin
      got.lightness        = lab.lightness;
      got.green_red_axis   = lab.green_red_axis;
      got.blue_yellow_axis = lab.blue_yellow_axis;
      if (pending_lab.size() == 0) begin
        $error("unexpected result transaction L=%0d a=%0d b=%0d",
               got.lightness, got.green_red_axis, got.blue_yellow_axis);
        failed = 1'b1;
      end else begin
        want = pending_lab.pop_front();
        if (got.lightness !== want.lightness) begin
          $error("lightness: expected %0d, got %0d", want.lightness, got.lightness);
          failed = 1'b1;
        end
        if (got.green_red_axis !== want.green_red_axis) begin
          $error("green_red_axis: expected %0d, got %0d",
                 want.green_red_axis, got.green_red_axis);
          failed = 1'b1;
        end
        if (got.blue_yellow_axis !== want.blue_yellow_axis) begin
          $error("blue_yellow_axis: expected %0d, got %0d",
                 want.blue_yellow_axis, got.blue_yellow_axis);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink side: ready pattern picked at random from four modes; one long hold-off
  // ---------------------------------------------------------------------------
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    int unsigned mode;
    int unsigned tick;
    lab.ready = 1'b0;
    mode = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        lab.ready = 1'b0;
      end else begin
        case (mode)
          0:       lab.ready = 1'b1;                          // no stall
          1:       lab.ready = ($urandom_range(0, 3) != 0);
          2:       lab.ready = ($urandom_range(0, 9) < 3);    // heavy stall
          default: lab.ready = (tick % 5) < 3;                // periodic
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // offer one pixel from a falling edge, return at the falling edge after accept
  task automatic offer_pixel(input logic [7:0] r, g, b, input bit typed, input lab_t want);
    int unsigned seen;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    seen      = pix_taken;
    pix.valid = 1'b1;
    pix.red   = r;
    pix.green = g;
    pix.blue  = b;
    row_typed = typed;
    row_lab   = want;
    do @(negedge clk_i); while (pix_taken == seen);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(8, 13));    // around the gamma knee
      3:       return 8'($urandom_range(0, 24));    // deep shadow, linear f segment
      default: return 8'($urandom);
    endcase
  endfunction

  pix_row_t dir_rows [] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0, 16'sd0, 16'sd0}},  // black
    '{8'd255, 8'd255, 8'd255, 1'b0, '0},   // white, L near 100
    '{8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},   // most negative a*
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},   // most negative b*
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},   // yellow, large b*
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},   // magenta, large a*
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd10,  8'd10,  8'd10,  1'b0, '0},   // last code on linear decode
    '{8'd11,  8'd11,  8'd11,  1'b0, '0},   // first code on gamma curve
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd24,  8'd24,  8'd24,  1'b0, '0},   // near the 0.008856 segment knee
    '{8'd25,  8'd25,  8'd25,  1'b0, '0},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{8'd254, 8'd254, 8'd254, 1'b0, '0},
    '{8'd170, 8'd85,  8'd170, 1'b0, '0},   // alternating bit patterns
    '{8'd85,  8'd170, 8'd85,  1'b0, '0}
  };

  initial begin
    lab_t none;
    none      = '0;
    row_typed = 1'b0;
    row_lab   = '0;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    for (int i = 0; i < 256; i++) decode_tab[i] = srgb_decode(i);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      offer_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].typed,
                  dir_rows[i].lab);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // stall the sink long enough that the pipeline backs up into the input
      if (n == NUM_RANDOM / 3) hold_req = 1'b1;
      if (n >= NUM_RANDOM / 3 && n < NUM_RANDOM / 3 + 100) burst_left = 10;
      if ($urandom_range(0, 1) == 0)
        offer_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, none);
      else
        offer_pixel(pick_code(), pick_code(), pick_code(), 1'b0, none);
    end
    pix.valid = 1'b0;

    while (pending_lab.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (!failed) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
